FILE: rtl/core/delta_robot_inverse_kinematics_assert.svh
// ---------------------------------------------------------------------------
// Delta robot inverse kinematics assertion macros
// Wraps concurrent checks so that they can be compiled out as a group.
// ---------------------------------------------------------------------------
`ifndef DELTA_ROBOT_INVERSE_KINEMATICS_ASSERT_SVH
`define DELTA_ROBOT_INVERSE_KINEMATICS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held
`define DRIK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delta IK check failed");

// Next-cycle implication, disabled while reset is held
`define DRIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delta IK check failed");

`else

`define DRIK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DRIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/drik_pkg.sv
// ---------------------------------------------------------------------------
// Delta robot inverse kinematics package
// Shared formats, command/status types and constant tables.
// ---------------------------------------------------------------------------
`default_nettype none

package drik_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int COORD_FRAC_BITS = 8;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    // Sequencer counter, covers the 32-entry arctangent table
    localparam int CNT_W = 5;

    // Square root steps (disc is below 2**52)
    localparam int SQ_K = 26;

    // Configuration register indexes
    localparam logic [2:0] CFG_PLATE_OFFSET = 3'd0;
    localparam logic [2:0] CFG_UPPER_ARM    = 3'd1;
    localparam logic [2:0] CFG_LOWER_ARM    = 3'd2;
    localparam logic [2:0] CFG_ANGLE_LOW    = 3'd3;
    localparam logic [2:0] CFG_ANGLE_HIGH   = 3'd4;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam logic signed [30:0] SQRT3_HALF_Q30 = 31'sd929887697;

    localparam logic signed [31:0] ATAN_TAB [32] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
        32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288,
        32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
        32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
        32'sd1024, 32'sd512, 32'sd256, 32'sd128,
        32'sd64, 32'sd32, 32'sd16, 32'sd8,
        32'sd4, 32'sd2, 32'sd1, 32'sd0
    };

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT,
        OP_PREP,
        OP_PROD,
        OP_COEF,
        OP_SQR,
        OP_DISC,
        OP_SQRT,
        OP_ANGLE,
        OP_CORD,
        OP_FIN,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       arm;
        logic [CNT_W-1:0] cnt;
        logic             ok;
        logic             report;
    } t_cmd;

    typedef struct packed {
        logic disc_neg;
        logic den_zero;
        logic ang_ok;
        logic row_start;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/core/drik_dp.sv
// ---------------------------------------------------------------------------
// Delta IK datapath
// Rotation, coefficients, discriminant, square root and CORDIC arctangent.
// ---------------------------------------------------------------------------
`default_nettype none

module drik_dp
    import drik_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_st,
    input  wire logic [31:0] i_in_data,   // pos_x, pos_y, pos_z, pad
    input  wire logic        i_in_user,   // row_start
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic [47:0]      o_out_data,  // angle_arm0, angle_arm1, angle_arm2
    output logic [1:0]       o_out_user   // reachable, report
);

    localparam int C      = COORD_FRAC_BITS;
    localparam int A      = ANGLE_FRAC_BITS;
    localparam int RW     = 42;
    localparam int SH     = 30 - C;
    localparam int RH     = 1 << (SH - 1);
    localparam int XA_W   = C + 12;
    localparam int PK1_W  = XA_W + 11;
    localparam int K1_W   = PK1_W + 1;
    localparam int KA_W   = PK1_W + 2;
    localparam int PSQ_W  = 2 * XA_W;
    localparam int SQS_W  = PSQ_W + 1;
    localparam int CH     = 1 << (C - 1);
    localparam int Q_W    = 23;
    localparam int K3_W   = C + 25;
    localparam int KC_W   = K3_W + 1;
    localparam int RS     = C - 4;
    localparam int RSH    = (RS > 0) ? (1 << (RS - 1)) : 0;
    localparam int COEF_W = 27;
    localparam int SQR_W  = 54;
    localparam int SQ_IN_W = 2 * SQ_K;
    localparam int SQT_W  = SQ_IN_W + 1;
    localparam int S_W    = SQ_K + 1;
    localparam int DEN_W  = 28;
    localparam int AS_W   = 29;
    localparam int CX_W   = 62;
    localparam int CZ_W   = 34;
    localparam int TZ_W   = CZ_W + 1;
    localparam int TH_SH  = 29 - A;
    localparam int TH_RH  = 1 << (28 - A);
    localparam int TH_W   = A + 6;
    localparam int CMP_W  = TH_W + 17;
    localparam int ANG_W  = 16;
    localparam longint PI_ANG = (PI_Q30 + (64'sd1 <<< (29 - A))) >>> (30 - A);

    // configuration
    logic [7:0]               r_po;
    logic [9:0]               r_l1;
    logic [9:0]               r_l2;
    logic signed [15:0]       r_lo;
    logic signed [15:0]       r_hi;

    // item and intermediate values
    logic signed [9:0]        r_x;
    logic signed [9:0]        r_y;
    logic signed [10:0]       r_z;
    logic                     r_row;
    logic signed [40:0]       r_xs;
    logic signed [40:0]       r_ys;
    logic signed [XA_W-1:0]   r_xa;
    logic signed [XA_W-1:0]   r_yr;
    logic signed [PSQ_W-1:0]  r_pxx;
    logic signed [PSQ_W-1:0]  r_pyy;
    logic signed [PK1_W-1:0]  r_pk1;
    logic signed [21:0]       r_pzl;
    logic signed [21:0]       r_pzz;
    logic [19:0]              r_pl1;
    logic [19:0]              r_pl2;
    logic signed [COEF_W-1:0] r_a;
    logic signed [COEF_W-1:0] r_b;
    logic signed [COEF_W-1:0] r_c;
    logic signed [SQR_W-1:0]  r_aa;
    logic signed [SQR_W-1:0]  r_bb;
    logic signed [SQR_W-1:0]  r_cc;
    logic signed [SQR_W-1:0]  r_disc;
    logic [SQ_IN_W-1:0]       r_rem;
    logic [SQ_IN_W-1:0]       r_root;
    logic signed [DEN_W-1:0]  r_den;
    logic                     r_pos;
    logic signed [CX_W-1:0]   r_cx;
    logic signed [CX_W-1:0]   r_cy;
    logic signed [CZ_W-1:0]   r_cz;
    logic [ANG_W-1:0]         r_ang [3];
    logic [47:0]              r_o_data;
    logic [1:0]               r_o_user;

    // combinational
    logic signed [RW-1:0]     xh;
    logic signed [RW-1:0]     yh;
    logic signed [RW-1:0]     t_ax;
    logic signed [RW-1:0]     t_ay;
    logic signed [RW-1:0]     t_bx;
    logic signed [RW-1:0]     t_by;
    logic signed [XA_W-1:0]   xr;
    logic signed [XA_W-1:0]   yr;
    logic signed [XA_W-1:0]   xa;
    logic signed [K1_W-1:0]   k1;
    logic signed [KA_W-1:0]   a_t;
    logic signed [SQS_W-1:0]  sq_t;
    logic signed [SQS_W-1:0]  sqr;
    logic signed [Q_W-1:0]    q;
    logic signed [K3_W-1:0]   k3;
    logic signed [KC_W-1:0]   c_t;
    logic signed [SQR_W-1:0]  disc;
    logic [SQ_IN_W-1:0]       bitv;
    logic [SQT_W-1:0]         trial;
    logic signed [S_W-1:0]    sv;
    logic signed [DEN_W-1:0]  den;
    logic signed [DEN_W-1:0]  dmag;
    logic signed [AS_W-1:0]   asum;
    logic signed [AS_W-1:0]   sma;
    logic signed [CX_W-1:0]   dx;
    logic signed [CX_W-1:0]   dy;
    logic signed [CZ_W-1:0]   atv;
    logic signed [TZ_W-1:0]   tz;
    logic signed [TH_W-1:0]   th;
    logic signed [CMP_W-1:0]  thc;
    logic                     ang_ok;

    always_comb begin
        // rotations by 120 and 240 degrees, rounded to Q(C)
        xh   = RW'(r_x) <<< 29;
        yh   = RW'(r_y) <<< 29;
        t_ax = (-xh - RW'(r_ys) + RW'(RH)) >>> SH;
        t_ay = (RW'(r_xs) - yh + RW'(RH)) >>> SH;
        t_bx = (-xh + RW'(r_ys) + RW'(RH)) >>> SH;
        t_by = (-RW'(r_xs) - yh + RW'(RH)) >>> SH;
        case (i_cmd.arm)
            2'd1: begin
                xr = XA_W'(t_ax);
                yr = XA_W'(t_ay);
            end
            2'd2: begin
                xr = XA_W'(t_bx);
                yr = XA_W'(t_by);
            end
            default: begin
                xr = XA_W'(r_x) <<< C;
                yr = XA_W'(r_y) <<< C;
            end
        endcase
        xa = xr + XA_W'($signed({1'b0, r_po, {C{1'b0}}}));

        // coefficients rounded to Q4
        k1   = $signed({r_pk1, 1'b0});
        a_t  = (KA_W'(k1) + KA_W'(RSH)) >>> RS;
        sq_t = SQS_W'(r_pxx) + SQS_W'(r_pyy) + SQS_W'(CH);
        sqr  = sq_t >>> C;
        q    = Q_W'(r_pzz) + Q_W'($signed({1'b0, r_pl1})) - Q_W'($signed({1'b0, r_pl2}));
        k3   = K3_W'(sqr) + (K3_W'(q) <<< C);
        c_t  = (KC_W'(k3) + KC_W'(RSH)) >>> RS;

        disc = r_aa + r_bb - r_cc;

        // one bit of the integer square root per step
        bitv  = SQ_IN_W'(1) << (2 * (SQ_K - 1 - int'(i_cmd.cnt)));
        trial = {1'b0, r_root} + {1'b0, bitv};

        // arctangent operands for the larger root
        sv   = $signed({1'b0, r_root[SQ_K-1:0]});
        den  = DEN_W'(r_c) - DEN_W'(r_b);
        dmag = den[DEN_W-1] ? -den : den;
        asum = AS_W'(r_a) + AS_W'(sv);
        sma  = AS_W'(sv) - AS_W'(r_a);

        dx  = r_cx >>> i_cmd.cnt;
        dy  = r_cy >>> i_cmd.cnt;
        atv = CZ_W'(ATAN_TAB[i_cmd.cnt]);

        // final angle: doubled CORDIC angle, or +/- pi on a zero divisor
        tz = (TZ_W'(r_cz) + TZ_W'(TH_RH)) >>> TH_SH;
        if (r_den == '0) begin
            th = r_pos ? TH_W'(PI_ANG) : -TH_W'(PI_ANG);
        end else begin
            th = TH_W'(tz);
        end
        thc    = CMP_W'(th);
        ang_ok = !(thc < CMP_W'(r_lo)) && !(thc > CMP_W'(r_hi));
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_po <= 8'd40;
            r_l1 <= 10'd80;
            r_l2 <= 10'd140;
            r_lo <= 16'sd0;
            r_hi <= 16'sd17157;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLATE_OFFSET: r_po <= i_cfg_data[7:0];
                CFG_UPPER_ARM:    r_l1 <= i_cfg_data[9:0];
                CFG_LOWER_ARM:    r_l2 <= i_cfg_data[9:0];
                CFG_ANGLE_LOW:    r_lo <= $signed(i_cfg_data);
                CFG_ANGLE_HIGH:   r_hi <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // datapath operations
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x   <= $signed(i_in_data[9:0]);
                r_y   <= $signed(i_in_data[19:10]);
                r_z   <= $signed(i_in_data[30:20]);
                r_row <= i_in_user;
            end
            OP_ROT: begin
                r_xs <= r_x * SQRT3_HALF_Q30;
                r_ys <= r_y * SQRT3_HALF_Q30;
            end
            OP_PREP: begin
                r_xa <= xa;
                r_yr <= yr;
            end
            OP_PROD: begin
                r_pxx <= r_xa * r_xa;
                r_pyy <= r_yr * r_yr;
                r_pk1 <= r_xa * $signed({1'b0, r_l1});
                r_pzl <= r_z * $signed({1'b0, r_l1});
                r_pzz <= r_z * r_z;
                r_pl1 <= r_l1 * r_l1;
                r_pl2 <= r_l2 * r_l2;
            end
            OP_COEF: begin
                r_a <= COEF_W'(a_t);
                r_b <= COEF_W'(r_pzl) <<< 5;
                r_c <= COEF_W'(c_t);
            end
            OP_SQR: begin
                r_aa <= r_a * r_a;
                r_bb <= r_b * r_b;
                r_cc <= r_c * r_c;
            end
            OP_DISC: begin
                r_disc <= disc;
                r_rem  <= disc[SQ_IN_W-1:0];
                r_root <= '0;
            end
            OP_SQRT: begin
                if ({1'b0, r_rem} >= trial) begin
                    r_rem  <= r_rem - trial[SQ_IN_W-1:0];
                    r_root <= (r_root >> 1) + bitv;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            OP_ANGLE: begin
                r_den <= den;
                r_pos <= asum > AS_W'(0);
                r_cx  <= CX_W'(dmag) <<< 30;
                r_cy  <= (den[DEN_W-1] ? CX_W'(sma) : CX_W'(asum)) <<< 30;
                r_cz  <= '0;
            end
            OP_CORD: begin
                if (!r_cy[CX_W-1]) begin
                    r_cx <= r_cx + dy;
                    r_cy <= r_cy - dx;
                    r_cz <= r_cz + atv;
                end else begin
                    r_cx <= r_cx - dy;
                    r_cy <= r_cy + dx;
                    r_cz <= r_cz - atv;
                end
            end
            OP_FIN: begin
                r_ang[i_cmd.arm] <= ANG_W'(th);
            end
            OP_OUT: begin
                r_o_data <= i_cmd.ok ? {r_ang[2], r_ang[1], r_ang[0]} : '0;
                r_o_user <= {i_cmd.report, i_cmd.ok};
            end
            default: ;
        endcase
    end

    assign o_st.disc_neg  = r_disc[SQR_W-1];
    assign o_st.den_zero  = (r_den == '0);
    assign o_st.ang_ok    = ang_ok;
    assign o_st.row_start = r_row;
    assign o_out_data     = r_o_data;
    assign o_out_user     = r_o_user;

endmodule

`default_nettype wire

FILE: rtl/core/drik_ctrl.sv
// ---------------------------------------------------------------------------
// Delta IK controller
// Sequences the datapath over three arms and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "delta_robot_inverse_kinematics_assert.svh"

module drik_ctrl
    import drik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_stat i_st
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_ROT  = 12'b0000_0000_0010,
        S_PREP = 12'b0000_0000_0100,
        S_PROD = 12'b0000_0000_1000,
        S_COEF = 12'b0000_0001_0000,
        S_SQR  = 12'b0000_0010_0000,
        S_DISC = 12'b0000_0100_0000,
        S_ROOT = 12'b0000_1000_0000,
        S_ANG  = 12'b0001_0000_0000,
        S_CORD = 12'b0010_0000_0000,
        S_FIN  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_arm, n_arm;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ok, n_ok;
    logic             r_last, n_last;
    logic             r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_arm    = r_arm;
        n_cnt    = r_cnt;
        n_ok     = r_ok;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd.op     = OP_NONE;
        o_cmd.arm    = r_arm;
        o_cmd.cnt    = r_cnt;
        o_cmd.ok     = r_ok;
        o_cmd.report = r_ok && !i_st.row_start && r_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_arm    = 2'd0;
                    n_cnt    = '0;
                    n_state  = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                n_state  = S_PREP;
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = S_PROD;
            end
            S_PROD: begin
                o_cmd.op = OP_PROD;
                n_state  = S_COEF;
            end
            S_COEF: begin
                o_cmd.op = OP_COEF;
                n_state  = S_SQR;
            end
            S_SQR: begin
                o_cmd.op = OP_SQR;
                n_state  = S_DISC;
            end
            S_DISC: begin
                o_cmd.op = OP_DISC;
                n_cnt    = '0;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                if (i_st.disc_neg) begin
                    // no real root: drop the point
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SQRT;
                    if (r_cnt == CNT_W'(SQ_K - 1)) begin
                        n_cnt   = '0;
                        n_state = S_ANG;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_ANG: begin
                o_cmd.op = OP_ANGLE;
                n_cnt    = '0;
                n_state  = S_CORD;
            end
            S_CORD: begin
                if (i_st.den_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_CORD;
                    if (r_cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
                        n_cnt   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                if (!i_st.ang_ok) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else if (r_arm == 2'd2) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_arm   = r_arm + 1'b1;
                    n_state = S_PREP;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_last   = r_ok;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_arm    <= 2'd0;
            r_cnt    <= '0;
            r_ok     <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_arm    <= n_arm;
            r_cnt    <= n_cnt;
            r_ok     <= n_ok;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    `DRIK_ASSERT_NEXT(as_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_ROT)
    `DRIK_ASSERT_NEXT(as_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && (!r_ovalid || i_out_ready), r_ovalid && (r_state == S_IDLE) && (r_last == $past(r_ok)))
    `DRIK_ASSERT_NEXT(as_last_arm_ok, i_clk, i_rst_n, (r_state == S_FIN) && i_st.ang_ok && (r_arm == 2'd2), (r_state == S_DONE) && r_ok)

endmodule

`default_nettype wire

FILE: rtl/core/delta_robot_inverse_kinematics.sv
// ---------------------------------------------------------------------------
// Delta robot inverse kinematics
// Joint angles of a three-arm delta robot for one effector point per request.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one request per effector point. tdata holds pos_x,
//   pos_y, pos_z; tuser carries row_start for the first point of a row.
//   Master stream m_axis_*: one result per request, tdata holds the three
//   joint angles (Q2.13 rad), tuser holds reachable and report.
//   Configuration: write i_cfg_data to register i_cfg_index on i_cfg_we,
//   only while no request is in flight.
//   A point that fails an arm returns sooner than a reachable one. Each arm
//   runs a 26-step square root and N = CORDIC_ITERATIONS CORDIC steps (none
//   on a zero divisor) on one shared unit, so a new request is accepted only
//   once the previous point has left the datapath for the output register.
//   The result sits in an output register, so the next request is taken
//   while a result still waits; if the receiver stalls past the next
//   solution, the controller holds in its done state until the slot frees.
//   Reset (synchronous, active low) restores register defaults, empties the
//   output slot and clears the previous-point flag.
// ---------------------------------------------------------------------------
`default_nettype none

module delta_robot_inverse_kinematics
    import drik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // pos_x[9:0], pos_y[19:10], pos_z[30:20], zero
    input  wire logic        s_axis_tuser,   // row_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // angle_arm0, angle_arm1, angle_arm2
    output logic [1:0]       m_axis_tuser,   // reachable, report
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // controller to datapath commands, datapath status back
    t_cmd  cmd;
    t_stat st;

    drik_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_cmd      (cmd),
        .i_st       (st)
    );

    drik_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_st       (st),
        .i_in_data  (s_axis_tdata),
        .i_in_user  (s_axis_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out_data (m_axis_tdata),
        .o_out_user (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tb_delta_robot_inverse_kinematics.sv
// ---------------------------------------------------------------------------
// Delta robot inverse kinematics testbench
// Feeds effector points through the request stream and checks every result
// against a bit-exact predictor. A directed table comes first, then random
// points under several register settings and receiver/sender idle patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_delta_robot_inverse_kinematics;
    import drik_pkg::*;

    localparam int NUM_ITER = CORDIC_ITERATIONS_DEF;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    // Latency of a reachable point plus margin
    localparam int DRAIN_CYCLES = 3 * (33 + NUM_ITER) + 60;

    typedef struct {
        logic              reach;
        logic signed [15:0] ang0;
        logic signed [15:0] ang1;
        logic signed [15:0] ang2;
        logic              report;
    } ik_result_t;

    typedef struct {
        int   x;
        int   y;
        int   z;
        bit   rs;
        bit   typed;        // expectation typed in below
        bit   exp_reach;
    } point_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    delta_robot_inverse_kinematics i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of registers and row state
    longint  plate_off, arm_up, arm_low, lim_lo, lim_hi;
    bit      prev_reach;

    ik_result_t pending_angles[$];
    int      fail_cnt = 0;
    int      sent_cnt = 0;
    int      tx_idle_pct = 13;
    int      rx_idle_pct = 68;
    logic    rx_hold = 1'b0;

    // shift right, ties toward plus infinity; >>> floors on signed values
    function automatic longint rnd_up(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC, atan2(n, d) for d > 0, Q30 radians
    function automatic longint atan_q30(longint n, longint d);
        longint cx, cy, cz, nx;
        cx = d <<< 30;
        cy = n <<< 30;
        cz = 0;
        for (int i = 0; i < NUM_ITER && i < 32; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + longint'(ATAN_TAB[i]);
            end else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - longint'(ATAN_TAB[i]);
            end
            cx = nx;
        end
        return cz;
    endfunction

    function automatic bit arm_angle(longint xr, longint yr, longint z, output longint th);
        longint one, xa, k1, k2, k3, a, b, c, disc, s, den, pi_q;
        one = longint'(1) <<< COORD_FRAC_BITS;
        xa = xr + plate_off * one;
        k1 = 2 * xa * arm_up;
        k2 = 2 * z * arm_up * one;
        k3 = rnd_up(xa * xa + yr * yr, COORD_FRAC_BITS)
           + (z * z + arm_up * arm_up - arm_low * arm_low) * one;
        a = rnd_up(k1, COORD_FRAC_BITS - 4);
        b = rnd_up(k2, COORD_FRAC_BITS - 4);
        c = rnd_up(k3, COORD_FRAC_BITS - 4);
        disc = a * a + b * b - c * c;
        th = 0;
        if (disc < 0) return 1'b0;
        s = int_sqrt(longint'(disc));
        den = c - b;
        if (den == 0) begin
            // zero divisor: plus or minus pi by the numerator sign
            pi_q = rnd_up(PI_Q30, 30 - ANGLE_FRAC_BITS);
            th = (a + s > 0) ? pi_q : -pi_q;
        end else if (den > 0) begin
            th = rnd_up(atan_q30(a + s, den), 29 - ANGLE_FRAC_BITS);
        end else begin
            th = rnd_up(atan_q30(s - a, -den), 29 - ANGLE_FRAC_BITS);
        end
        return (th >= lim_lo && th <= lim_hi);
    endfunction

    // Joint angles for one point; advances the row state
    function automatic ik_result_t predict_angles(int px, int py, int pz, bit rs);
        ik_result_t r;
        longint x, y, z, th;
        longint xr[3], yr[3], ang[3];
        bit ok;
        x = px; y = py; z = pz;
        xr[0] = x <<< COORD_FRAC_BITS;
        yr[0] = y <<< COORD_FRAC_BITS;
        xr[1] = rnd_up(-x * (longint'(1) <<< 29) - y * longint'(SQRT3_HALF_Q30),
                       30 - COORD_FRAC_BITS);
        yr[1] = rnd_up(x * longint'(SQRT3_HALF_Q30) - y * (longint'(1) <<< 29),
                       30 - COORD_FRAC_BITS);
        xr[2] = rnd_up(-x * (longint'(1) <<< 29) + y * longint'(SQRT3_HALF_Q30),
                       30 - COORD_FRAC_BITS);
        yr[2] = rnd_up(-x * longint'(SQRT3_HALF_Q30) - y * (longint'(1) <<< 29),
                       30 - COORD_FRAC_BITS);
        ok = 1'b1;
        ang = '{0, 0, 0};
        // stop at the first arm that fails
        for (int i = 0; i < 3 && ok; i++) begin
            ok = arm_angle(xr[i], yr[i], z, th);
            ang[i] = th;
        end
        if (!ok) ang = '{0, 0, 0};
        r.reach  = ok;
        r.ang0   = ang[0][15:0];
        r.ang1   = ang[1][15:0];
        r.ang2   = ang[2][15:0];
        r.report = ok && !rs && prev_reach;
        prev_reach = ok;
        return r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_PLATE_OFFSET: plate_off = val[7:0];
            CFG_UPPER_ARM:    arm_up    = val[9:0];
            CFG_LOWER_ARM:    arm_low   = val[9:0];
            CFG_ANGLE_LOW:    lim_lo    = longint'($signed(val));
            CFG_ANGLE_HIGH:   lim_hi    = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic cfg_set(int po, int l1, int l2, int lo, int hi);
        cfg_write(CFG_PLATE_OFFSET, 16'(po));
        cfg_write(CFG_UPPER_ARM, 16'(l1));
        cfg_write(CFG_LOWER_ARM, 16'(l2));
        cfg_write(CFG_ANGLE_LOW, 16'(lo));
        cfg_write(CFG_ANGLE_HIGH, 16'(hi));
        // unknown index must leave everything alone
        cfg_write(CFG_UNUSED, 16'($urandom));
    endtask

    // Drain all results and let the pipeline go quiet before a register write
    task automatic wait_idle();
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one request; hold valid until it is taken
    task automatic send_point(int x, int y, int z, bit rs, output ik_result_t exp_r);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, 11'(z), 10'(y), 10'(x)};
        s_axis_tuser  <= rs;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_r = predict_angles(x, y, z, rs);
        pending_angles.push_back(exp_r);
        sent_cnt++;
    endtask

    task automatic send_random(int count);
        ik_result_t e;
        int span, sxy, x, y, z;
        for (int n = 0; n < count; n++) begin
            if (sent_cnt < 400) begin
                tx_idle_pct = 13; rx_idle_pct = 68;
            end else if (sent_cnt < 750) begin
                tx_idle_pct = 68; rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            span = int'(arm_up + arm_low);
            if (span > 1023) span = 1023;
            sxy = span / 2 + int'(plate_off) / 2;
            if (sxy > 511) sxy = 511;
            if ($urandom_range(99) < 80) begin
                // mostly points near the work envelope
                x = $urandom_range(2 * sxy) - sxy;
                y = $urandom_range(2 * sxy) - sxy;
                z = -int'($urandom_range(span));
            end else begin
                x = int'($urandom_range(1023)) - 512;
                y = int'($urandom_range(1023)) - 512;
                z = int'($urandom_range(2047)) - 1024;
            end
            send_point(x, y, z, ($urandom_range(7) == 0), e);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: check each taken result, then decide on the next stall
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                fail_cnt++;
            end else begin
                ik_result_t e;
                e = pending_angles.pop_front();
                if (m_axis_tuser[0] !== e.reach) begin
                    $display("%0t: reachable exp %b got %b", $time, e.reach, m_axis_tuser[0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:0] !== e.ang0) begin
                    $display("%0t: angle_arm0 exp %0d got %0d", $time, e.ang0,
                             $signed(m_axis_tdata[15:0]));
                    fail_cnt++;
                end
                if (m_axis_tdata[31:16] !== e.ang1) begin
                    $display("%0t: angle_arm1 exp %0d got %0d", $time, e.ang1,
                             $signed(m_axis_tdata[31:16]));
                    fail_cnt++;
                end
                if (m_axis_tdata[47:32] !== e.ang2) begin
                    $display("%0t: angle_arm2 exp %0d got %0d", $time, e.ang2,
                             $signed(m_axis_tdata[47:32]));
                    fail_cnt++;
                end
                if (m_axis_tuser[1] !== e.report) begin
                    $display("%0t: report exp %b got %b", $time, e.report, m_axis_tuser[1]);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n)
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver stall so that the output slot fills and input backs up
    initial begin
        wait (sent_cnt >= 150);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (3000) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #50000000;
        $display("FAIL delta_robot_inverse_kinematics");
        $finish;
    end

    initial begin
        point_row_t dir_rows[$];
        ik_result_t e;
        plate_off = 40; arm_up = 80; arm_low = 140; lim_lo = 0; lim_hi = 17157;
        prev_reach = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under reset defaults; far points are typed unreachable
        dir_rows = '{
            '{0, 0, -150, 1, 0, 0},
            '{0, 0, -160, 0, 0, 0},
            '{10, -10, -170, 0, 0, 0},
            '{0, 0, -1024, 0, 1, 0},
            '{-512, -512, -1024, 0, 1, 0},
            '{511, 511, 1023, 0, 1, 0},
            '{511, -512, 0, 1, 1, 0},
            '{-512, 511, -1024, 0, 1, 0},
            '{0, 0, -150, 0, 0, 0},
            '{0, 0, -150, 0, 0, 0},
            '{0, 0, -150, 1, 0, 0},
            '{0, 0, 0, 0, 0, 0},
            '{0, 0, 1023, 0, 1, 0},
            '{-40, 0, -100, 0, 0, 0},
            '{30, 30, -200, 0, 0, 0},
            '{0, 0, -219, 0, 0, 0},
            '{0, 0, -60, 0, 0, 0}
        };
        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].rs, e);
            if (dir_rows[i].typed && e.reach !== dir_rows[i].exp_reach) begin
                $display("%0t: row %0d table exp reach %b predictor %b",
                         $time, i, dir_rows[i].exp_reach, e.reach);
                fail_cnt++;
            end
        end
        s_axis_tvalid <= 1'b0;
        wait_idle();

        send_random(300);
        wait_idle();
        cfg_set(255, 1023, 1023, -25736, 25736);
        send_random(120);
        wait_idle();
        cfg_set(0, 1, 1, -25736, 25736);
        send_random(80);
        wait_idle();
        // reversed limits: nothing passes
        cfg_set(40, 80, 140, 17157, 0);
        send_random(60);
        wait_idle();
        cfg_set(10, 50, 120, -8000, 25736);
        send_random(200);
        wait_idle();
        cfg_set(40, 80, 140, 0, 17157);
        send_random(240);

        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASS delta_robot_inverse_kinematics");
        else
            $display("FAIL delta_robot_inverse_kinematics");
        $finish;
    end

endmodule

`default_nettype wire
